// ----- rtl/clock_watermark_evictor_top_assert.svh -----
// ---------------------------------------------------------------------------
// clock_watermark_evictor_top_assert.svh
// Assertion macros used by the evictor RTL.
// ---------------------------------------------------------------------------
`ifndef CLOCK_WATERMARK_EVICTOR_TOP_ASSERT_SVH
`define CLOCK_WATERMARK_EVICTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CWE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CWE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cwe_pkg.sv -----
// ---------------------------------------------------------------------------
// cwe_pkg
// Types, codes and constants of the CLOCK watermark evictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwe_pkg;

    // Table depth default and walk length factor
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int STEP_FACTOR     = 2;

    // Field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int SIZE_W  = 32;
    localparam int BYTES_W = 40;
    localparam int PCT_W   = 7;
    localparam int CIDX_W  = 2;

    // Scaled arithmetic: 100 * 40-bit value fits in 47 bits, plus sign/margin
    localparam int HOLD_W = BYTES_W + PCT_W;
    localparam int ACC_W  = HOLD_W + 2;

    localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);

    // Opcodes
    localparam logic [OP_W-1:0] OP_TOUCH  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_PASS   = 2'd2;

    // Result kinds
    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_CAPACITY  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HIGH_PCT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LOW_PCT   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_LAST_TIER = 2'd3;

    // Configuration reset values
    localparam logic [BYTES_W-1:0] CAPACITY_RST = '0;
    localparam logic [PCT_W-1:0]   HIGH_PCT_RST = PCT_W'(90);
    localparam logic [PCT_W-1:0]   LOW_PCT_RST  = PCT_W'(75);
    localparam logic               LAST_TIER_RST = 1'b0;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [SLOT_W-1:0]  slot;
        logic [SIZE_W-1:0]  entry_size;
        logic [BYTES_W-1:0] tier_usage;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  victim_slot;
        logic [SIZE_W-1:0]  victim_size;
        logic               demote;
        logic [BYTES_W-1:0] freed_total;
        logic               last;
    } out_item_t;

    // Request to the shared add/subtract unit
    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

// ----- rtl/cwe_alu.sv -----
// ---------------------------------------------------------------------------
// cwe_alu
// Shared add/subtract unit used by the multiply, compare, deficit and freed-total steps of a pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwe_alu
(
    input  cwe_pkg::alu_req_t              req,
    output logic [cwe_pkg::ACC_W-1:0]      sum
);

    logic [cwe_pkg::ACC_W-1:0] b_eff;

    // Subtract as a + ~b + 1
    assign b_eff = req.sub ? ~req.b : req.b;
    assign sum   = req.a + b_eff + cwe_pkg::ACC_W'(req.sub);

endmodule

// ----- rtl/clock_watermark_evictor_top.sv -----
// ---------------------------------------------------------------------------
// clock_watermark_evictor_top
// CLOCK second-chance evictor for one tier with high/low watermarks.
//
//   channel   dir   handshake               payload
//   in        in    in_valid / in_stall     cwe_pkg::in_item_t
//   out       out   out_valid / out_stall   cwe_pkg::out_item_t
//   cfg       in    cfg_we                  cfg_index, cfg_data
//
// Touch and insert transactions are handled in the idle state. A pass scales used
// bytes and both watermarks by shift-add through the single shared adder
// (a compare follows the high watermark, a subtract the low one), then walks
// the table: a fetch and a step per slot, a freed update, three deficit
// subtracts and an emit per victim, a final stop check and the done result.
// Reset clears valid/visited bits, hand and config; the size memory needs no
// clearing. An output stall holds the sequencer in its emit or done state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_watermark_evictor_top
#(
    parameter int TABLE_DEPTH = cwe_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cwe_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cwe_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [cwe_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [cwe_pkg::BYTES_W-1:0]   cfg_data
);

    localparam int HAND_W     = $clog2(TABLE_DEPTH);
    localparam int EXT_W      = HAND_W + cwe_pkg::SLOT_W;
    localparam int WALK_STEPS = TABLE_DEPTH * cwe_pkg::STEP_FACTOR;
    localparam int STEP_W     = $clog2(WALK_STEPS + 1);
    localparam int CNT_W      = $clog2(cwe_pkg::PCT_W);

    localparam logic [CNT_W-1:0]  MUL_LAST  = CNT_W'(cwe_pkg::PCT_W - 1);
    localparam logic [HAND_W-1:0] HAND_LAST = HAND_W'(TABLE_DEPTH - 1);
    localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(WALK_STEPS);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_MUL   = 12'b000000000010,
        S_CMP   = 12'b000000000100,
        S_DEF   = 12'b000000001000,
        S_FETCH = 12'b000000010000,
        S_STEP  = 12'b000000100000,
        S_FREED = 12'b000001000000,
        S_SUB6  = 12'b000010000000,
        S_SUB5  = 12'b000100000000,
        S_SUB2  = 12'b001000000000,
        S_EMIT  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    typedef enum logic [1:0] {
        MSEL_USED,
        MSEL_HIGH,
        MSEL_LOW
    } mul_sel_t;

    // Configuration registers
    logic [cwe_pkg::BYTES_W-1:0] cap_reg;
    logic [cwe_pkg::PCT_W-1:0]   high_pct_reg;
    logic [cwe_pkg::PCT_W-1:0]   low_pct_reg;
    logic                        last_tier_reg;

    // Sequencer state
    state_t                      state_reg, state_next;
    mul_sel_t                    mul_sel_reg, mul_sel_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [cwe_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [cwe_pkg::HOLD_W-1:0]  hold_reg, hold_next;
    logic [cwe_pkg::BYTES_W-1:0] used_reg, used_next;
    logic [cwe_pkg::BYTES_W-1:0] freed_reg, freed_next;
    logic [STEP_W-1:0]           steps_reg, steps_next;
    logic [HAND_W-1:0]           hand_reg, hand_next;
    logic [HAND_W-1:0]           vslot_reg, vslot_next;
    logic [cwe_pkg::SIZE_W-1:0]  vsize_reg, vsize_next;

    // Slot table flags
    logic [TABLE_DEPTH-1:0]      valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0]      visited_reg, visited_next;

    // Output register
    logic                        out_valid_reg;
    cwe_pkg::out_item_t          out_reg, out_next;
    logic                        out_load;
    logic                        out_free;

    // Size memory
    logic [cwe_pkg::SIZE_W-1:0]  size_mem [TABLE_DEPTH];
    logic [cwe_pkg::SIZE_W-1:0]  size_q;
    logic                        mem_we;

    // Misc decode
    logic                        in_accept;
    logic [EXT_W-1:0]            slot_ext;
    logic [HAND_W-1:0]           slot_idx;
    logic                        slot_ok;
    logic [EXT_W-1:0]            vslot_ext;
    logic [cwe_pkg::BYTES_W-1:0] mcand;
    logic [cwe_pkg::PCT_W-1:0]   mul_bits;
    logic                        deficit_met;

    cwe_pkg::alu_req_t           alu_req;
    logic [cwe_pkg::ACC_W-1:0]   alu_sum;

    cwe_alu u_alu
    (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign slot_ext  = EXT_W'(in_data.slot);
    assign slot_idx  = slot_ext[HAND_W-1:0];
    assign slot_ok   = (32'(in_data.slot) < TABLE_DEPTH);
    assign vslot_ext = EXT_W'(vslot_reg);

    // Walk stops once the scaled deficit is no longer positive
    assign deficit_met = acc_reg[cwe_pkg::ACC_W-1] || (acc_reg == '0);

    // Multiplicand and multiplier bits for the shift-add sequence
    always_comb
    begin
        mcand    = cap_reg;
        mul_bits = cwe_pkg::PCT_SCALE;
        case (mul_sel_reg)
            MSEL_USED:
            begin
                mcand    = used_reg;
                mul_bits = cwe_pkg::PCT_SCALE;
            end
            MSEL_HIGH: mul_bits = high_pct_reg;
            MSEL_LOW:  mul_bits = low_pct_reg;
            default:   mul_bits = cwe_pkg::PCT_SCALE;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        mul_sel_next = mul_sel_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        hold_next    = hold_reg;
        used_next    = used_reg;
        freed_next   = freed_reg;
        steps_next   = steps_reg;
        hand_next    = hand_reg;
        vslot_next   = vslot_reg;
        vsize_next   = vsize_reg;
        valid_next   = valid_reg;
        visited_next = visited_reg;
        out_next     = out_reg;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        alu_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_data.opcode)
                        cwe_pkg::OP_TOUCH:
                        begin
                            if (slot_ok && valid_reg[slot_idx])
                                visited_next[slot_idx] = 1'b1;
                        end
                        cwe_pkg::OP_INSERT:
                        begin
                            if (slot_ok)
                            begin
                                valid_next[slot_idx]   = 1'b1;
                                visited_next[slot_idx] = 1'b0;
                                mem_we                 = 1'b1;
                            end
                        end
                        cwe_pkg::OP_PASS:
                        begin
                            used_next    = in_data.tier_usage;
                            freed_next   = '0;
                            steps_next   = '0;
                            acc_next     = '0;
                            cnt_next     = MUL_LAST;
                            mul_sel_next = MSEL_USED;
                            state_next   = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end

            // One multiplier bit per cycle, MSB first
            S_MUL:
            begin
                alu_req.a = {acc_reg[cwe_pkg::ACC_W-2:0], 1'b0};
                alu_req.b = mul_bits[cnt_reg] ? cwe_pkg::ACC_W'(mcand) : '0;
                acc_next  = alu_sum;
                if (cnt_reg == '0)
                begin
                    case (mul_sel_reg)
                        MSEL_USED:
                        begin
                            hold_next    = alu_sum[cwe_pkg::HOLD_W-1:0];
                            acc_next     = '0;
                            cnt_next     = MUL_LAST;
                            mul_sel_next = MSEL_HIGH;
                        end
                        MSEL_HIGH: state_next = S_CMP;
                        MSEL_LOW:  state_next = S_DEF;
                        default:   state_next = S_DONE;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // Pressure: 100*used > capacity*high_percent, with capacity nonzero
            S_CMP:
            begin
                alu_req.a   = cwe_pkg::ACC_W'(hold_reg);
                alu_req.b   = acc_reg;
                alu_req.sub = 1'b1;
                if ((cap_reg != '0) && !alu_sum[cwe_pkg::ACC_W-1] && (alu_sum != '0))
                begin
                    acc_next     = '0;
                    cnt_next     = MUL_LAST;
                    mul_sel_next = MSEL_LOW;
                    state_next   = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Scaled deficit: 100*used - capacity*low_percent
            S_DEF:
            begin
                alu_req.a   = cwe_pkg::ACC_W'(hold_reg);
                alu_req.b   = acc_reg;
                alu_req.sub = 1'b1;
                acc_next    = alu_sum;
                state_next  = S_FETCH;
            end

            // Size of the slot under the hand is read here
            S_FETCH:
            begin
                if (deficit_met || (steps_reg == STEP_MAX))
                    state_next = S_DONE;
                else
                    state_next = S_STEP;
            end

            S_STEP:
            begin
                state_next = S_FETCH;
                if (valid_reg[hand_reg])
                begin
                    if (visited_reg[hand_reg])
                    begin
                        visited_next[hand_reg] = 1'b0;
                    end
                    else
                    begin
                        valid_next[hand_reg]   = 1'b0;
                        visited_next[hand_reg] = 1'b0;
                        vslot_next             = hand_reg;
                        vsize_next             = size_q;
                        state_next             = S_FREED;
                    end
                end
                hand_next  = (hand_reg == HAND_LAST) ? '0 : hand_reg + 1'b1;
                steps_next = steps_reg + 1'b1;
            end

            S_FREED:
            begin
                alu_req.a  = cwe_pkg::ACC_W'(freed_reg);
                alu_req.b  = cwe_pkg::ACC_W'(vsize_reg);
                freed_next = alu_sum[cwe_pkg::BYTES_W-1:0];
                state_next = S_SUB6;
            end

            // Deficit -= 100*size as 64+32+4 times size
            S_SUB6:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = cwe_pkg::ACC_W'({vsize_reg, 6'b0});
                alu_req.sub = 1'b1;
                acc_next    = alu_sum;
                state_next  = S_SUB5;
            end

            S_SUB5:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = cwe_pkg::ACC_W'({vsize_reg, 5'b0});
                alu_req.sub = 1'b1;
                acc_next    = alu_sum;
                state_next  = S_SUB2;
            end

            S_SUB2:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = cwe_pkg::ACC_W'({vsize_reg, 2'b0});
                alu_req.sub = 1'b1;
                acc_next    = alu_sum;
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.kind        = cwe_pkg::KIND_VICTIM;
                    out_next.victim_slot = vslot_ext[cwe_pkg::SLOT_W-1:0];
                    out_next.victim_size = vsize_reg;
                    out_next.demote      = !last_tier_reg;
                    out_next.freed_total = freed_reg;
                    out_next.last        = 1'b0;
                    state_next           = S_FETCH;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.kind        = cwe_pkg::KIND_DONE;
                    out_next.victim_slot = '0;
                    out_next.victim_size = '0;
                    out_next.demote      = 1'b0;
                    out_next.freed_total = freed_reg;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_sel_reg   <= MSEL_USED;
            cnt_reg       <= '0;
            steps_reg     <= '0;
            hand_reg      <= '0;
            valid_reg     <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_sel_reg <= mul_sel_next;
            cnt_reg     <= cnt_next;
            steps_reg   <= steps_next;
            hand_reg    <= hand_next;
            valid_reg   <= valid_next;
            visited_reg <= visited_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        hold_reg  <= hold_next;
        used_reg  <= used_next;
        freed_reg <= freed_next;
        vslot_reg <= vslot_next;
        vsize_reg <= vsize_next;
        out_reg   <= out_next;
    end

    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= cwe_pkg::CAPACITY_RST;
            high_pct_reg  <= cwe_pkg::HIGH_PCT_RST;
            low_pct_reg   <= cwe_pkg::LOW_PCT_RST;
            last_tier_reg <= cwe_pkg::LAST_TIER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cwe_pkg::REG_CAPACITY:  cap_reg       <= cfg_data;
                cwe_pkg::REG_HIGH_PCT:  high_pct_reg  <= cfg_data[cwe_pkg::PCT_W-1:0];
                cwe_pkg::REG_LOW_PCT:   low_pct_reg   <= cfg_data[cwe_pkg::PCT_W-1:0];
                cwe_pkg::REG_LAST_TIER: last_tier_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Entry size memory, registered read at the hand
    always_ff @(posedge clk)
    begin
        if (mem_we)
            size_mem[slot_idx] <= in_data.entry_size;
        size_q <= size_mem[hand_reg];
    end

    // Assertions
    `include "clock_watermark_evictor_top_assert.svh"

    `CWE_ASSERT_IMP(a_steps_bound, clk, rst_n, 1'b1, steps_reg <= STEP_MAX, "walk overran")
    `CWE_ASSERT_IMP(a_victim_cleared, clk, rst_n, state_reg == S_FREED, !valid_reg[vslot_reg], "victim still valid")
    `CWE_ASSERT_NXT(a_freed_grows, clk, rst_n, state_reg == S_FREED, freed_reg >= $past(freed_reg), "freed total shrank")
    `CWE_ASSERT_NXT(a_done_to_idle, clk, rst_n, (state_reg == S_DONE) && out_free, state_reg == S_IDLE, "pass did not end")

endmodule
